// ===== src/twc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_pkg: shared types and constants for the thinning window classifier
// bit positions of the 3x3 window, ring order and per-stage word layouts
// ----------------------------------------------------------------------------
package twc_pkg;

    localparam int unsigned WINDOW_W = 9;

    // bit positions inside the window
    localparam int unsigned BIT_NW = 8;
    localparam int unsigned BIT_N  = 7;
    localparam int unsigned BIT_NE = 6;
    localparam int unsigned BIT_W  = 5;
    localparam int unsigned BIT_C  = 4;
    localparam int unsigned BIT_E  = 3;
    localparam int unsigned BIT_SW = 2;
    localparam int unsigned BIT_S  = 1;
    localparam int unsigned BIT_SE = 0;

    localparam int unsigned RING_LEN = 8;

    // outer ring walked clockwise, starting at the nw corner
    localparam int unsigned RING_BITS [RING_LEN] = '{
        BIT_NW, BIT_N, BIT_NE, BIT_E, BIT_SE, BIT_S, BIT_SW, BIT_W
    };

    typedef logic [WINDOW_W-1:0] window_t;

    // after stage 1: center, edge pixels and ring run starts
    typedef struct packed {
        logic                center;
        logic [3:0]          edges;
        logic [RING_LEN-1:0] starts;
    } twc_ring_t;

    // after stage 2: center plus the two counts
    typedef struct packed {
        logic       center;
        logic [2:0] edge_cnt;
        logic [3:0] run_cnt;
    } twc_count_t;

    // after stage 3: the result word
    typedef struct packed {
        logic deletable;
        logic insertable;
        logic prunable;
    } twc_flags_t;

    // one flag per ring position that opens a run holding an edge pixel
    function automatic logic [RING_LEN-1:0] ring_starts(input window_t w);
        logic [RING_LEN-1:0] ring;
        logic [RING_LEN-1:0] flags;
        begin
            for (int i = 0; i < RING_LEN; i++)
            begin
                ring[i] = w[RING_BITS[i]];
            end
            for (int i = 0; i < RING_LEN; i++)
            begin
                // even positions are corners: they count only if the next edge is set
                flags[i] = ring[i] && !ring[(i + RING_LEN - 1) % RING_LEN]
                           && ((i % 2) == 1 || ring[(i + 1) % RING_LEN]);
            end
            return flags;
        end
    endfunction

endpackage

// ===== src/twc_ring_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_ring_stage: first pipeline stage
// splits the window into center and edge pixels and marks ring run starts
// ----------------------------------------------------------------------------
module twc_ring_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  twc_pkg::window_t  in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output twc_pkg::twc_ring_t out_word
);
    import twc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    twc_ring_t word_reg;
    twc_ring_t word_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
        word_next.center = in_word[BIT_C];
        word_next.edges  = {in_word[BIT_N], in_word[BIT_E], in_word[BIT_S], in_word[BIT_W]};
        word_next.starts = ring_starts(in_word);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== src/twc_count_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_count_stage: second pipeline stage
// counts set edge pixels and ring runs that hold an edge
// ----------------------------------------------------------------------------
module twc_count_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  twc_pkg::twc_ring_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output twc_pkg::twc_count_t out_word
);
    import twc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    twc_count_t word_reg;
    twc_count_t word_next;
    logic [2:0] edge_sum;
    logic [3:0] run_sum;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        edge_sum = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            edge_sum = edge_sum + {2'b00, in_word.edges[i]};
        end
        run_sum = 4'd0;
        for (int i = 0; i < RING_LEN; i++)
        begin
            run_sum = run_sum + {3'b000, in_word.starts[i]};
        end
        word_next.center   = in_word.center;
        word_next.edge_cnt = edge_sum;
        word_next.run_cnt  = run_sum;
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== src/twc_decide_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_decide_stage: third pipeline stage and output register
// turns the counts into the deletable, insertable and prunable flags
// ----------------------------------------------------------------------------
module twc_decide_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  twc_pkg::twc_count_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output twc_pkg::twc_flags_t out_word
);
    import twc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    twc_flags_t word_reg;
    twc_flags_t word_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        // two or three of the n, e, s and w pixels set, all in one ring run
        word_next.deletable  = in_word.center
                               && (in_word.edge_cnt == 3'd2 || in_word.edge_cnt == 3'd3)
                               && (in_word.run_cnt <= 4'd1);
        word_next.insertable = !in_word.center && (in_word.edge_cnt != 3'd0);
        word_next.prunable   = in_word.center && (in_word.edge_cnt == 3'd1);
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== src/thinning_window_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thinning_window_classifier: 3x3 window classifier for binary thinning
// flags a center pixel as deletable, insertable or prunable under 4-adjacency
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_ready carry one 9-bit window word
//     (bit 8 nw .. bit 0 se, center at bit 4)
//   output channel: out_valid / out_ready carry one result word made of
//     deletable, insertable and prunable
//   every window gives exactly one result word, in order
// timing
//   three register stages: ring scan, counts, decision; a window passes
//   through the ring, count and decision registers in that order, and the
//   decision register is the output register
//   throughput is one window per cycle while out_ready stays high
// reset
//   rst_n clears every stage valid bit; the pipeline comes up empty and
//   in_ready is high right after reset
// stall
//   each stage holds its word while the next one is full and blocked, so a
//   low out_ready fills the pipe; in_ready drops only once all three stages
//   hold a word, and bubbles between words close up during a stall
// ----------------------------------------------------------------------------
module thinning_window_classifier (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  twc_pkg::window_t window,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             deletable,
    output logic             insertable,
    output logic             prunable
);
    import twc_pkg::*;

    // stage handshakes
    logic       ring_valid;
    logic       ring_ready;
    twc_ring_t  ring_word;
    logic       count_valid;
    logic       count_ready;
    twc_count_t count_word;
    twc_flags_t flags_word;

    // stage 1: edge pixels and ring run starts
    twc_ring_stage u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (window),
        .out_valid (ring_valid),
        .out_ready (ring_ready),
        .out_word  (ring_word)
    );

    // stage 2: edge count and run count
    twc_count_stage u_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ring_valid),
        .in_ready  (ring_ready),
        .in_word   (ring_word),
        .out_valid (count_valid),
        .out_ready (count_ready),
        .out_word  (count_word)
    );

    // stage 3: flags, held in the output register
    twc_decide_stage u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (count_valid),
        .in_ready  (count_ready),
        .in_word   (count_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (flags_word)
    );

    assign deletable  = flags_word.deletable;
    assign insertable = flags_word.insertable;
    assign prunable   = flags_word.prunable;

    // the three flags exclude each other
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(deletable && insertable))
        else $error("deletable and insertable both set");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(deletable && prunable))
        else $error("deletable and prunable both set");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(insertable && prunable))
        else $error("insertable and prunable both set");

    // input back-pressure only when every stage is full and the output waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready && ring_valid && count_valid))
        else $error("in_ready low without a full, stalled pipeline");

endmodule

// ===== tb/tb_thinning_window_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thinning_window_classifier: self-checking bench for the window classifier
// sends 3x3 windows through the valid/ready input, predicts the three flags
// of every accepted window and compares them with the result words in order,
// while the sender idles in bursts and the receiver stalls on its own pattern
// ----------------------------------------------------------------------------

import twc_pkg::*;

class window_scoreboard;
    twc_flags_t expected_flags[$];
    int         mismatches;
    int         windows_seen;
    int         results_seen;
    int         deletable_seen;
    int         insertable_seen;
    int         prunable_seen;

    function new();
        mismatches      = 0;
        windows_seen    = 0;
        results_seen    = 0;
        deletable_seen  = 0;
        insertable_seen = 0;
        prunable_seen   = 0;
    endfunction

    // three flags of one window under 4-adjacency
    function twc_flags_t classify_window(window_t w);
        logic [RING_LEN-1:0] ring;
        int                  edge_cnt;
        int                  edge_runs;
        int                  prev;
        twc_flags_t          flags;
        flags     = '0;
        edge_runs = 0;
        for (int i = 0; i < RING_LEN; i++)
        begin
            ring[i] = w[RING_BITS[i]];
        end
        edge_cnt = int'(w[BIT_N]) + int'(w[BIT_E]) + int'(w[BIT_S]) + int'(w[BIT_W]);
        // count ring runs of set pixels that hold at least one edge pixel;
        // a run opening on a corner holds an edge only if the next pixel is set
        for (int i = 0; i < RING_LEN; i++)
        begin
            prev = (i + RING_LEN - 1) % RING_LEN;
            if (ring[i] && !ring[prev])
            begin
                if ((i % 2) == 1 || ring[(i + 1) % RING_LEN])
                begin
                    edge_runs++;
                end
            end
        end
        if (w[BIT_C])
        begin
            if (edge_cnt == 1)
            begin
                flags.prunable = 1'b1;
            end
            else if (edge_cnt == 2 || edge_cnt == 3)
            begin
                flags.deletable = (edge_runs <= 1);
            end
        end
        else
        begin
            flags.insertable = (edge_cnt != 0);
        end
        return flags;
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function void note_window(window_t w);
        windows_seen++;
        expected_flags.push_back(classify_window(w));
    endfunction

    task check_result(logic del, logic ins, logic prn);
        twc_flags_t exp_f;
        results_seen++;
        if (expected_flags.size() == 0)
        begin
            report_mismatch($sformatf("result word %0d with no window pending",
                                      results_seen));
        end
        else
        begin
            exp_f = expected_flags.pop_front();
            if (del !== exp_f.deletable)
            begin
                report_mismatch($sformatf("word %0d deletable got %b want %b",
                                          results_seen, del, exp_f.deletable));
            end
            if (ins !== exp_f.insertable)
            begin
                report_mismatch($sformatf("word %0d insertable got %b want %b",
                                          results_seen, ins, exp_f.insertable));
            end
            if (prn !== exp_f.prunable)
            begin
                report_mismatch($sformatf("word %0d prunable got %b want %b",
                                          results_seen, prn, exp_f.prunable));
            end
        end
        if (del === 1'b1) deletable_seen++;
        if (ins === 1'b1) insertable_seen++;
        if (prn === 1'b1) prunable_seen++;
    endtask

    function int pending();
        return expected_flags.size();
    endfunction
endclass

module tb_thinning_window_classifier;

    localparam int RANDOM_WINDOWS = 1800;
    localparam int IDLE_LIMIT     = 2000;   // cycles with no word moving on either side
    localparam int DRAIN_CYCLES   = 12;     // extra cycles after the last pending result

    logic    clk        = 1'b0;
    logic    rst_n      = 1'b0;
    logic    in_valid   = 1'b0;
    logic    in_ready;
    window_t window_w   = '0;
    logic    out_valid;
    logic    out_ready  = 1'b0;
    logic    deletable;
    logic    insertable;
    logic    prunable;

    logic [15:0] stall_cycle = '0;
    int          idle_cycles = 0;

    window_scoreboard sb = new();

    always #10 clk = ~clk;

    thinning_window_classifier u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .window     (window_w),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .deletable  (deletable),
        .insertable (insertable),
        .prunable   (prunable)
    );

    // receiver: four stall modes in turn, picked by stall_cycle[9:8]
    //   mode 0 never stalls, mode 1 stalls at random,
    //   mode 2 drops ready whenever stall_cycle is a multiple of five, mode 3 holds long stalls
    //   so the pipe fills and in_ready has to drop
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1'b1;
        case (stall_cycle[9:8])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ($urandom_range(0, 9) < 7);
            2'd2:    out_ready <= ((stall_cycle % 5) != 0);
            default: out_ready <= (stall_cycle[3:0] < 4'd6);
        endcase
    end

    // result monitor: values seen here are the ones from before the edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(deletable, insertable, prunable);
        end
    end

    // watchdog on cycles where no word moves
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // hold the window on the port until the block takes it
    task send_window(input window_t w);
        in_valid <= 1'b1;
        window_w <= w;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_window(w);
    endtask

    task idle_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // mostly centers that are set, where the run test matters
    function automatic window_t random_window();
        window_t w;
        int      kind;
        w    = window_t'($urandom_range(0, 511));
        kind = $urandom_range(0, 9);
        if (kind >= 4 && kind < 8)
        begin
            w[BIT_C] = 1'b1;
        end
        else if (kind >= 8)
        begin
            w[BIT_C] = 1'b0;
        end
        return w;
    endfunction

    // corner cases: empty, full, lone center, interior pixel, hole,
    // endpoints, opposite edges, adjacent edges with and without the
    // corner between them, three of the n, e, s, w pixels split and joined, corners only
    window_t directed_windows[] = '{
        9'h000, 9'h1FF, 9'h010, 9'h0BA, 9'h1EF,
        9'h090, 9'h018, 9'h030, 9'h012, 9'h080,
        9'h100, 9'h002, 9'h092, 9'h038, 9'h098,
        9'h0D8, 9'h0B8, 9'h1F8, 9'h0BF, 9'h155,
        9'h145, 9'h01B, 9'h03E, 9'h0AA, 9'h0AB
    };

    initial
    begin
        int sent;
        int burst;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed windows back to back
        foreach (directed_windows[i])
        begin
            send_window(directed_windows[i]);
        end
        idle_sender(4);

        // random windows in bursts with random gaps, some gaps empty
        sent = 0;
        while (sent < RANDOM_WINDOWS)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < RANDOM_WINDOWS; k++)
            begin
                send_window(random_window());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                idle_sender($urandom_range(1, 8));
            end
        end
        in_valid <= 1'b0;

        // drain: wait for every pending result, then a few more cycles
        while (sb.pending() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d windows and %0d result words under bursty input and stalls",
                 sb.windows_seen, sb.results_seen);
        $display("flags seen: deletable %0d, insertable %0d, prunable %0d, mismatches %0d",
                 sb.deletable_seen, sb.insertable_seen, sb.prunable_seen, sb.mismatches);
        if (sb.mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/twc_pkg.sv
src/twc_ring_stage.sv
src/twc_count_stage.sv
src/twc_decide_stage.sv
src/thinning_window_classifier.sv
tb/tb_thinning_window_classifier.sv
